[sv/credit_limited_line_queue_core_assert.svh]
`ifndef CREDIT_LIMITED_LINE_QUEUE_CORE_ASSERT_SVH
`define CREDIT_LIMITED_LINE_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset
`define CLQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("clq assertion failed");

// Next-cycle implication, checked at every clock edge outside reset
`define CLQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("clq assertion failed");

`endif

[sv/clq_pkg.sv]
package clq_pkg;

    localparam int QUEUE_DEPTH        = 64;
    localparam int HANDLE_BITS        = 16;
    localparam int LINE_ID_W          = 16;
    localparam int MAX_RESULTS        = 64;
    localparam int IDX_W              = $clog2(QUEUE_DEPTH);
    localparam int CNT_W              = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W              = $clog2(MAX_RESULTS + 1);
    localparam int LIMIT_W            = 7;
    localparam int KIND_W             = 2;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    typedef logic [HANDLE_BITS-1:0] t_handle;
    typedef logic [LINE_ID_W-1:0]   t_line_id;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [RES_W-1:0]       t_res;
    typedef logic [LIMIT_W-1:0]     t_limit;
    typedef logic [KIND_W-1:0]      t_kind;

    localparam t_kind KIND_ADD   = 2'd0;
    localparam t_kind KIND_TICK  = 2'd1;
    localparam t_kind KIND_FLUSH = 2'd2;
    localparam t_kind KIND_ERASE = 2'd3;

    localparam t_limit RESET_CREDIT_LIMIT = 7'd5;

    // Register word index, taken from paddr[2]
    localparam logic REG_CREDIT_LIMIT = 1'b0;

endpackage

[sv/credit_limited_line_queue_core.sv]
// Credit-limited line queue. An add (kind 0) queues a line handle, dropping it
// when all 64 slots are full; an erase (kind 3) empties the queue; neither
// produces a transfer. A flush (kind 2) releases queued handles in order, one
// credit each, until the queue is empty or used credits reach credit_limit
// (APB register 0, reset 5); the last handle of the item carries o_last. A tick
// (kind 1) returns one credit when any is used and then flushes if handles
// wait. Handles live in a single-port synchronous RAM with a registered read,
// so each release issues the read and then loads the output register, and
// o_stall stays high for the whole flush, also while the output is stalled.
// The output register lets the next item be accepted while the final handle
// still waits to be taken.
module credit_limited_line_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  clq_pkg::t_kind                      i_kind,
    input  clq_pkg::t_line_id                   i_line_id,
    output logic                                o_valid,
    input  logic                                i_stall,
    output clq_pkg::t_line_id                   o_out_line_id,
    output logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clq_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [clq_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [clq_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

`include "credit_limited_line_queue_core_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam clq_pkg::t_cnt FULL_CNT  = clq_pkg::t_cnt'(clq_pkg::QUEUE_DEPTH);
    localparam clq_pkg::t_idx LAST_SLOT = clq_pkg::t_idx'(clq_pkg::QUEUE_DEPTH - 1);
    localparam clq_pkg::t_res MAX_RES   = clq_pkg::t_res'(clq_pkg::MAX_RESULTS);

    clq_pkg::t_handle  r_store [clq_pkg::QUEUE_DEPTH];
    clq_pkg::t_handle  r_rd_data;

    logic [1:0]        r_state, n_state;
    clq_pkg::t_idx     r_head, n_head;
    clq_pkg::t_idx     r_tail, n_tail;
    clq_pkg::t_cnt     r_fill, n_fill;
    clq_pkg::t_limit   r_used, n_used;
    clq_pkg::t_limit   r_limit;
    clq_pkg::t_res     r_count, n_count;
    logic              r_last_pend, n_last_pend;
    logic              r_out_valid, n_out_valid;
    logic              r_out_last, n_out_last;
    clq_pkg::t_line_id r_out_id, n_out_id;

    logic              in_xfer;
    logic              out_xfer;
    logic              wr_en;
    logic              rd_en;
    logic              can_release;
    logic              cfg_wr;
    logic [clq_pkg::LIMIT_W:0] used_inc;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_out_line_id = r_out_id;
    assign o_last   = r_out_last;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == clq_pkg::REG_CREDIT_LIMIT)
                    ? clq_pkg::APB_DATA_W'(r_limit) : '0;

    assign wr_en       = in_xfer && (i_kind == clq_pkg::KIND_ADD) && (r_fill != FULL_CNT);
    assign can_release = (r_fill != '0) && (r_used < r_limit) && (r_count != MAX_RES);
    assign rd_en       = (r_state == ST_RD) && can_release;
    assign used_inc    = {1'b0, r_used} + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_used      = r_used;
        n_count     = r_count;
        n_last_pend = r_last_pend;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_out_last  = r_out_last;
        n_out_id    = r_out_id;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_count = '0;
                    case (i_kind)
                        clq_pkg::KIND_ADD: begin
                            if (wr_en) begin
                                n_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        clq_pkg::KIND_TICK: begin
                            if (r_used != '0) begin
                                n_used = r_used - 1'b1;
                                if (r_fill != '0) begin
                                    n_state = ST_RD;
                                end
                            end
                        end
                        clq_pkg::KIND_FLUSH: begin
                            n_state = ST_RD;
                        end
                        default: begin
                            n_head = r_tail;
                            n_fill = '0;
                        end
                    endcase
                end
            end
            ST_RD: begin
                if (can_release) begin
                    n_head      = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                    n_fill      = r_fill - 1'b1;
                    n_used      = r_used + 1'b1;
                    n_count     = r_count + 1'b1;
                    n_last_pend = (r_fill == clq_pkg::t_cnt'(1))
                               || (used_inc >= {1'b0, r_limit})
                               || (r_count + 1'b1 == MAX_RES);
                    n_state     = ST_WAIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || out_xfer) begin
                    n_out_valid = 1'b1;
                    n_out_id    = clq_pkg::t_line_id'(r_rd_data);
                    n_out_last  = r_last_pend;
                    n_state     = r_last_pend ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_used      <= '0;
            r_count     <= '0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_limit     <= clq_pkg::RESET_CREDIT_LIMIT;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_used      <= n_used;
            r_count     <= n_count;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            if (cfg_wr && paddr[2] == clq_pkg::REG_CREDIT_LIMIT) begin
                r_limit <= clq_pkg::t_limit'(pwdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_id <= n_out_id;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_tail] <= clq_pkg::t_handle'(i_line_id);
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_head];
        end
    end

    `CLQ_ASSERT_NOW(a_empty_ptrs, r_fill == '0, r_head == r_tail)
    `CLQ_ASSERT_NOW(a_partial_ptrs, (r_fill != '0) && (r_fill != FULL_CNT), r_head != r_tail)
    `CLQ_ASSERT_NOW(a_wait_has_credit, r_state == ST_WAIT, r_used != '0)
    `CLQ_ASSERT_NEXT(a_release_from_rd, rd_en, (r_state == ST_WAIT) && (r_count != '0))

endmodule
